FILE: design/b32idc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 identifier checker package
// Character codes, layout limits, the uppercase value table and the
// character classification record shared by the checker modules.
// ----------------------------------------------------------------------------
package b32idc_pkg;

    localparam logic [7:0] C_COLON      = 8'h3A;
    localparam logic [7:0] C_UNDERSCORE = 8'h5F;
    localparam logic [7:0] C_DIGIT_0    = 8'h30;
    localparam logic [7:0] C_DIGIT_9    = 8'h39;
    localparam logic [7:0] C_UPPER_A    = 8'h41;
    localparam logic [7:0] C_UPPER_Z    = 8'h5A;
    localparam logic [7:0] C_LOWER_A    = 8'h61;
    localparam logic [7:0] C_LOWER_Z    = 8'h7A;
    localparam logic [7:0] C_UPPER_I    = 8'h49;
    localparam logic [7:0] C_UPPER_L    = 8'h4C;
    localparam logic [7:0] C_UPPER_O    = 8'h4F;
    localparam logic [7:0] C_UPPER_U    = 8'h55;

    localparam logic [4:0] C_MAX_LEN      = 5'd20;
    localparam logic [4:0] C_MIN_LEN      = 5'd9;
    localparam logic [4:0] C_BODY_MIN     = 5'd7;
    localparam logic [4:0] C_BODY_MAX     = 5'd13;
    localparam logic [4:0] C_POS_SAT      = 5'd21;
    localparam logic [4:0] C_SLUG_END     = 5'd7;
    localparam logic [4:0] C_BODY_NO_SLUG = 5'd2;
    localparam logic [4:0] C_POS_TYPE     = 5'd0;
    localparam logic [4:0] C_POS_SEP      = 5'd1;
    localparam logic [4:0] C_POS_SLUG     = 5'd2;

    // Value modulo 32 of each uppercase letter, indexed by its offset from A.
    // The letters I, L, O and U take 58 to 61 reduced modulo 32.
    localparam logic [4:0] C_UPPER_VALUE [32] = '{
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
        5'd26, 5'd18, 5'd19, 5'd27, 5'd20, 5'd21, 5'd28, 5'd22,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd29, 5'd27, 5'd28, 5'd29,
        5'd30, 5'd31, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    typedef struct packed {
        logic       is_colon;
        logic       is_under;
        logic       is_upper;
        logic       is_lower;
        logic       is_crock;
        logic [4:0] upper_val;
        logic [4:0] lower_val;
        logic [4:0] crock_val;
    } t_char_info;

endpackage

FILE: design/b32idc_char_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character classifier
// Sorts one byte into the classes the identifier layout needs and gives its
// checksum value for each class.
// ----------------------------------------------------------------------------
module b32idc_char_class (
    input  logic [7:0]             i_byte,
    output b32idc_pkg::t_char_info o_info
);

    logic       is_digit;
    logic       is_upper;
    logic       is_lower;
    logic       is_ilou;
    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic [7:0] digit_off;

    always_comb begin
        is_digit  = (i_byte >= b32idc_pkg::C_DIGIT_0) && (i_byte <= b32idc_pkg::C_DIGIT_9);
        is_upper  = (i_byte >= b32idc_pkg::C_UPPER_A) && (i_byte <= b32idc_pkg::C_UPPER_Z);
        is_lower  = (i_byte >= b32idc_pkg::C_LOWER_A) && (i_byte <= b32idc_pkg::C_LOWER_Z);
        is_ilou   = (i_byte == b32idc_pkg::C_UPPER_I) || (i_byte == b32idc_pkg::C_UPPER_L) ||
                    (i_byte == b32idc_pkg::C_UPPER_O) || (i_byte == b32idc_pkg::C_UPPER_U);
        upper_off = i_byte - b32idc_pkg::C_UPPER_A;
        lower_off = i_byte - b32idc_pkg::C_LOWER_A;
        digit_off = i_byte - b32idc_pkg::C_DIGIT_0;

        o_info.is_colon  = (i_byte == b32idc_pkg::C_COLON);
        o_info.is_under  = (i_byte == b32idc_pkg::C_UNDERSCORE);
        o_info.is_upper  = is_upper;
        o_info.is_lower  = is_lower;
        o_info.is_crock  = is_digit || (is_upper && !is_ilou);
        o_info.upper_val = b32idc_pkg::C_UPPER_VALUE[upper_off[4:0]];
        o_info.lower_val = lower_off[4:0];
        o_info.crock_val = is_digit ? digit_off[4:0]
                                    : b32idc_pkg::C_UPPER_VALUE[upper_off[4:0]];
    end

endmodule

FILE: design/base32_id_checksum_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 identifier checksum validator
// Checks the layout and the modulo-32 checksum of a streamed identifier.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless o_stall is high and gives one
// result for each byte marked final. Each byte is held in an input register,
// then classified and folded into a 5-bit running sum and a small position
// counter in the next cycle, and a final byte instead loads the result register.
// Input is stalled only when a final byte waits for the result register while an
// earlier result is still held there.
module base32_id_checksum_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_id_valid
);

    logic       r_s1_valid;
    logic       r_s1_final;
    logic [7:0] r_s1_byte;
    logic       n_s1_valid;

    logic [4:0] r_pos;
    logic [4:0] r_acc;
    logic       r_slug;
    logic       r_err;
    logic [4:0] n_pos;
    logic [4:0] n_acc;
    logic       n_slug;
    logic       n_err;

    logic       r_out_valid;
    logic       r_id_valid;
    logic       n_out_valid;

    logic       in_accept;
    logic       out_free;
    logic       s1_move;
    logic       ok;
    logic [4:0] data_first;
    logic [4:0] u_pos;
    logic [4:0] u_acc;
    logic       u_slug;
    logic       u_err;

    b32idc_pkg::t_char_info info;

    b32idc_char_class u_class (
        .i_byte (r_s1_byte),
        .o_info (info)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign s1_move   = r_s1_valid && (!r_s1_final || out_free);
    assign o_stall   = r_s1_valid && !s1_move;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_id_valid = r_id_valid;

    always_comb begin
        u_pos  = r_pos;
        u_acc  = r_acc;
        u_slug = r_slug;
        u_err  = r_err;
        if (info.is_colon) begin
            u_pos  = '0;
            u_acc  = '0;
            u_slug = 1'b0;
            u_err  = 1'b0;
        end else begin
            if (r_pos < b32idc_pkg::C_MAX_LEN) begin
                if (r_pos == b32idc_pkg::C_POS_TYPE) begin
                    if (info.is_upper) begin
                        u_acc = r_acc + info.upper_val;
                    end else begin
                        u_err = 1'b1;
                    end
                end else if (r_pos == b32idc_pkg::C_POS_SEP) begin
                    if (!info.is_under) begin
                        u_err = 1'b1;
                    end
                end else begin
                    u_slug = r_slug || ((r_pos == b32idc_pkg::C_POS_SLUG) && info.is_lower);
                    if (u_slug && (r_pos < b32idc_pkg::C_SLUG_END)) begin
                        if (info.is_lower) begin
                            u_acc = r_acc + info.lower_val;
                        end else begin
                            u_err = 1'b1;
                        end
                    end else if (info.is_crock) begin
                        u_acc = r_acc + info.crock_val;
                    end else begin
                        u_err = 1'b1;
                    end
                end
            end
            if (r_pos < b32idc_pkg::C_POS_SAT) begin
                u_pos = r_pos + 5'd1;
            end
        end

        data_first = u_slug ? b32idc_pkg::C_SLUG_END : b32idc_pkg::C_BODY_NO_SLUG;
        ok = !u_err
            && (u_pos >= b32idc_pkg::C_MIN_LEN) && (u_pos <= b32idc_pkg::C_MAX_LEN)
            && (u_pos >= data_first + b32idc_pkg::C_BODY_MIN)
            && (u_pos <= data_first + b32idc_pkg::C_BODY_MAX)
            && (u_acc == 5'd0);

        n_pos  = r_pos;
        n_acc  = r_acc;
        n_slug = r_slug;
        n_err  = r_err;
        if (s1_move) begin
            if (r_s1_final) begin
                n_pos  = '0;
                n_acc  = '0;
                n_slug = 1'b0;
                n_err  = 1'b0;
            end else begin
                n_pos  = u_pos;
                n_acc  = u_acc;
                n_slug = u_slug;
                n_err  = u_err;
            end
        end

        priority if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end

        priority if (s1_move && r_s1_final) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_slug      <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_slug      <= n_slug;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte  <= i_text_byte;
            r_s1_final <= i_is_final;
        end
        if (s1_move && r_s1_final) begin
            r_id_valid <= ok;
        end
    end

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result register valid after reset.");

    a_stall_only_on_blocked_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_final && r_out_valid && i_stall))
        else $error("Input stalled without a blocked final byte.");

    a_position_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= b32idc_pkg::C_POS_SAT)
        else $error("Suffix position beyond saturation.");

    a_final_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_final) |=> (r_pos == 5'd0 && r_acc == 5'd0 && !r_slug && !r_err))
        else $error("State not cleared after a final byte.");

    a_slug_after_separator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slug |-> (r_pos > b32idc_pkg::C_POS_SLUG))
        else $error("Slug flag set before the slug position.");

endmodule
